// ===== rtl/instruction_class_decoder_defines.svh =====
// Assertion macros used by the checker file of the instruction class decoder.
`ifndef INSTRUCTION_CLASS_DECODER_DEFINES_SVH
`define INSTRUCTION_CLASS_DECODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ICD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("instruction class decoder check failed");

// The consequent must hold in the cycle after the antecedent.
`define ICD_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("instruction class decoder check failed");

`endif

// ===== rtl/icd_pkg.sv =====
`default_nettype none

package icd_pkg;

   typedef logic [15:0] word_type;
   typedef logic [6:0]  op_id_type;
   typedef logic [2:0]  class_type;

   localparam op_id_type OP_UNDEF = 7'd0;
   localparam op_id_type OP_EXT   = 7'd1;

   localparam class_type CLASS_SYSTEM    = 3'd0;
   localparam class_type CLASS_REG_MEM   = 3'd1;
   localparam class_type CLASS_STACK_MEM = 3'd2;
   localparam class_type CLASS_IMM_ALU   = 3'd3;
   localparam class_type CLASS_SHIFT     = 3'd4;
   localparam class_type CLASS_MISC      = 3'd5;
   localparam class_type CLASS_EXTENSION = 3'd6;
   localparam class_type CLASS_RESERVED  = 3'd7;

endpackage

`default_nettype wire

// ===== rtl/icd_channels.sv =====
`default_nettype none

interface icd_req_if;
   import icd_pkg::*;

   logic     valid;
   logic     ready;
   word_type instruction_word;

   modport source (output valid, output instruction_word, input ready);
   modport sink (input valid, input instruction_word, output ready);
endinterface

interface icd_rsp_if;
   import icd_pkg::*;

   logic      valid;
   logic      ready;
   op_id_type operation_id;
   class_type instruction_class;
   logic      is_undefined;
   logic      is_extension;

   modport source (
      output valid, output operation_id, output instruction_class,
      output is_undefined, output is_extension, input ready
   );
   modport sink (
      input valid, input operation_id, input instruction_class,
      input is_undefined, input is_extension, output ready
   );
endinterface

`default_nettype wire

// ===== rtl/instruction_class_decoder.sv =====
// An accepted request is held in an input register, decoded by combinational logic
// and stored in the response register. Throughput: one transaction per cycle while
// the response channel does not stall; back-pressure holds both registers.
// Reset is synchronous and active high: it clears both valid flags, so the
// block holds no transaction afterwards. Payload registers are not reset.
`default_nettype none

module instruction_class_decoder (
   input  logic     clock,
   input  logic     reset,
   icd_req_if.sink   req_channel,
   icd_rsp_if.source rsp_channel
);
   import icd_pkg::*;

   logic      word_valid_ff;
   logic      word_valid_in;
   word_type  word_ff;
   word_type  word_in;
   logic      word_ready;

   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   op_id_type op_id_ff;
   op_id_type op_id_in;
   class_type class_ff;
   class_type class_in;
   logic      undef_ff;
   logic      undef_in;
   logic      ext_ff;
   logic      ext_in;
   logic      rsp_stage_ready;

   logic [3:0] sys_op1;
   logic [1:0] sys_op2;
   logic [2:0] op1;
   logic [1:0] op2;
   op_id_type  id;

   assign rsp_stage_ready   = !rsp_valid_ff || rsp_channel.ready;
   assign word_ready        = !word_valid_ff || rsp_stage_ready;
   assign req_channel.ready = word_ready;

   assign class_in = word_ff[15:13];
   assign sys_op1  = word_ff[12:9];
   assign sys_op2  = word_ff[7:6];
   assign op1      = word_ff[12:10];
   assign op2      = word_ff[9:8];

   always_comb begin
      id = OP_UNDEF;
      case (class_in)
         CLASS_SYSTEM: begin
            case (sys_op1)
               4'd0: id = (sys_op2 != 2'd3) ? 7'd2 + {5'd0, sys_op2} : OP_UNDEF;
               4'd1: id = (sys_op2 inside {2'd0, 2'd1}) ? 7'd5 + {5'd0, sys_op2} : OP_UNDEF;
               4'd2: id = 7'd7 + {5'd0, sys_op2};
               4'd3: id = (sys_op2 != 2'd3) ? 7'd11 + {5'd0, sys_op2} : OP_UNDEF;
               default: id = 7'd10 + {3'd0, sys_op1};
            endcase
         end
         CLASS_REG_MEM: begin
            id = (op2 != 2'd3) ? 7'd26 + {2'd0, op2, op1} : OP_UNDEF;
         end
         CLASS_STACK_MEM: id = 7'd50 + {4'd0, op1};
         CLASS_IMM_ALU:   id = 7'd58 + {4'd0, op1};
         CLASS_SHIFT: begin
            if (op1 == 3'd0) begin
               id = 7'd66;
            end else if (op1 == 3'd1) begin
               id = 7'd67;
            end else begin
               case (op2)
                  2'd0: id = 7'd66 + {4'd0, op1};
                  2'd1: id = 7'd72 + {4'd0, op1};
                  2'd2: id = (op1 inside {[3'd2:3'd5]}) ? 7'd78 + {4'd0, op1} : OP_UNDEF;
                  default: id = (op1 != 3'd7) ? 7'd82 + {4'd0, op1} : OP_UNDEF;
               endcase
            end
         end
         CLASS_MISC: begin
            case (op2)
               2'd0: id = 7'd89 + {4'd0, op1};
               2'd1: id = (op1 inside {[3'd0:3'd3]}) ? 7'd97 + {4'd0, op1} : OP_UNDEF;
               2'd2: id = (op1 inside {[3'd0:3'd4]}) ? 7'd101 + {4'd0, op1} : OP_UNDEF;
               default: id = OP_UNDEF;
            endcase
         end
         CLASS_EXTENSION: id = OP_EXT;
         CLASS_RESERVED:  id = OP_UNDEF;
         default:         id = OP_UNDEF;
      endcase
   end

   always_comb begin
      word_valid_in = word_valid_ff;
      word_in       = word_ff;
      if (word_ready) begin
         word_valid_in = req_channel.valid;
         word_in       = req_channel.instruction_word;
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_stage_ready) begin
         rsp_valid_in = word_valid_ff;
      end
      op_id_in = id;
      undef_in = (id == OP_UNDEF);
      ext_in   = (id == OP_EXT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         word_valid_ff <= word_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (word_ready && req_channel.valid) begin
         word_ff <= word_in;
      end
      if (rsp_stage_ready && word_valid_ff) begin
         op_id_ff <= op_id_in;
         class_ff <= class_in;
         undef_ff <= undef_in;
         ext_ff   <= ext_in;
      end
   end

   assign rsp_channel.valid             = rsp_valid_ff;
   assign rsp_channel.operation_id      = op_id_ff;
   assign rsp_channel.instruction_class = class_ff;
   assign rsp_channel.is_undefined      = undef_ff;
   assign rsp_channel.is_extension      = ext_ff;

endmodule

`default_nettype wire

// ===== rtl/icd_checker.sv =====
`default_nettype none

`include "instruction_class_decoder_defines.svh"

module icd_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire icd_pkg::op_id_type  rsp_operation_id,
   input wire icd_pkg::class_type  rsp_instruction_class,
   input wire logic                rsp_is_undefined,
   input wire logic                rsp_is_extension
);
   import icd_pkg::*;

   `ICD_ASSERT_NEXT(a_reset_empties, clock, reset, !rsp_valid)
   `ICD_ASSERT_NOW(a_undef_flag, clock, reset, rsp_valid, rsp_is_undefined == (rsp_operation_id == OP_UNDEF))
   `ICD_ASSERT_NOW(a_ext_flag, clock, reset, rsp_valid, rsp_is_extension == (rsp_instruction_class == CLASS_EXTENSION) && rsp_is_extension == (rsp_operation_id == OP_EXT))
   `ICD_ASSERT_NOW(a_reserved_undef, clock, reset, rsp_valid && rsp_instruction_class == CLASS_RESERVED, rsp_is_undefined)
   `ICD_ASSERT_NEXT(a_rsp_held, clock, !reset && rsp_valid && !rsp_ready, reset || rsp_valid)

endmodule

bind instruction_class_decoder icd_checker u_icd_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_channel.valid),
   .rsp_ready             (rsp_channel.ready),
   .rsp_operation_id      (rsp_channel.operation_id),
   .rsp_instruction_class (rsp_channel.instruction_class),
   .rsp_is_undefined      (rsp_channel.is_undefined),
   .rsp_is_extension      (rsp_channel.is_extension)
);

`default_nettype wire
